// ----- sv/integer_to_radix_ascii_assert.svh -----
// Assertion macros for the integer_to_radix_ascii RTL; itra_back is the file that uses them.
// Each macro expects clk and rst_n to be visible in the module that uses it.
`ifndef INTEGER_TO_RADIX_ASCII_ASSERT_SVH
`define INTEGER_TO_RADIX_ASCII_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define ITRA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("itra assertion failed");

// Next-cycle implication, checked outside reset.
`define ITRA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("itra assertion failed");

`endif

// ----- sv/itra_pkg.sv -----
// Package for the integer to radix ASCII converter: widths, character codes,
// transfer payload types, the back-end state type and the digit encoder.
// Depends on nothing.
package itra_pkg;

    localparam int VALUE_WIDTH    = 32;
    localparam int FIELD_WIDTH    = 32;
    localparam int RADIX_WIDTH    = 8;
    localparam int CHAR_WIDTH     = 8;
    localparam int MAX_DIGITS     = VALUE_WIDTH;
    localparam int DEPTH_WIDTH    = $clog2(MAX_DIGITS + 1);
    localparam int IDX_WIDTH      = $clog2(MAX_DIGITS);
    localparam int DIV_STEPS      = 4;
    localparam int DIV_CYCLES     = VALUE_WIDTH / DIV_STEPS;
    localparam int DIV_CNT_WIDTH  = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;
    localparam int FIFO_DEPTH     = 2;
    localparam int FIFO_PTR_WIDTH = $clog2(FIFO_DEPTH);

    localparam logic [CHAR_WIDTH-1:0]  CH_ZERO    = 8'h30;
    localparam logic [CHAR_WIDTH-1:0]  CH_UPPER_A = 8'h41;
    localparam logic [CHAR_WIDTH-1:0]  CH_MINUS   = 8'h2D;
    localparam logic [RADIX_WIDTH-1:0] RADIX_DEC  = 8'd10;
    localparam logic [RADIX_WIDTH-1:0] RADIX_MIN  = 8'd2;
    localparam logic [RADIX_WIDTH-1:0] DIGIT_MAX  = 8'd9;

    // One input transfer.
    typedef struct packed {
        logic [FIELD_WIDTH-1:0] value_bits;
        logic                   signed_mode;
        logic [RADIX_WIDTH-1:0] radix;
    } value_item_t;

    // One output transfer.
    typedef struct packed {
        logic [CHAR_WIDTH-1:0] char_code;
        logic                  last_char;
    } text_item_t;

    // Classified item as it waits in the queue.
    typedef struct packed {
        logic [VALUE_WIDTH-1:0] mag;
        logic [RADIX_WIDTH-1:0] radix;
        logic                   show_minus;
        logic                   is_zero;
    } front_item_t;

    // Divider status and results.
    typedef struct packed {
        logic                   done;
        logic [VALUE_WIDTH-1:0] quot;
        logic [RADIX_WIDTH-1:0] rem;
    } div_result_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SIGN,
        S_ZERO,
        S_START,
        S_WAIT,
        S_EMIT
    } back_state_t;

    // Digits above nine map to letters, wrapping modulo 256.
    function automatic logic [CHAR_WIDTH-1:0] digit_char(input logic [RADIX_WIDTH-1:0] d);
        logic [CHAR_WIDTH-1:0] code;
        if (d > DIGIT_MAX)
        begin
            code = CHAR_WIDTH'(d - RADIX_DEC + CH_UPPER_A);
        end
        else
        begin
            code = CHAR_WIDTH'(d + CH_ZERO);
        end
        return code;
    endfunction

endpackage

// ----- sv/itra_front.sv -----
// Front end: takes input transfers and classifies sign, magnitude and the
// single-zero case before the item enters the queue. Depends on itra_pkg.
module itra_front (
    input  logic                 value_valid,
    output logic                 value_ready,
    input  itra_pkg::value_item_t value_item,
    input  logic                 queue_full,
    output logic                 queue_push,
    output itra_pkg::front_item_t queue_item
);
    import itra_pkg::*;

    logic [VALUE_WIDTH-1:0] raw_mag;
    logic                   negative;
    logic [VALUE_WIDTH-1:0] abs_mag;

    // Handshake: an item is taken whenever the queue has room.
    assign value_ready = !queue_full;
    assign queue_push  = value_valid && !queue_full;

    // Sign handling: a negative signed value becomes its magnitude.
    assign raw_mag  = value_item.value_bits[VALUE_WIDTH-1:0];
    assign negative = value_item.signed_mode && raw_mag[VALUE_WIDTH-1];
    assign abs_mag  = negative ? (VALUE_WIDTH'(0) - raw_mag) : raw_mag;

    // Only base ten shows a minus sign; a zero value or a degenerate base prints "0".
    always_comb
    begin
        queue_item.mag        = abs_mag;
        queue_item.radix      = value_item.radix;
        queue_item.show_minus = negative && (value_item.radix == RADIX_DEC);
        queue_item.is_zero    = (abs_mag == '0) || (value_item.radix < RADIX_MIN);
    end

endmodule

// ----- sv/itra_fifo.sv -----
// Short queue between the front end and the back end.
// Depends on itra_pkg.
module itra_fifo (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  itra_pkg::front_item_t push_item,
    input  logic                  pop,
    output logic                  full,
    output logic                  head_valid,
    output itra_pkg::front_item_t head_item
);
    import itra_pkg::*;

    front_item_t               entry_reg [FIFO_DEPTH];
    logic [FIFO_PTR_WIDTH-1:0] wr_ptr_reg;
    logic [FIFO_PTR_WIDTH-1:0] rd_ptr_reg;
    logic [FIFO_PTR_WIDTH:0]   count_reg;
    logic [FIFO_PTR_WIDTH:0]   count_next;

    assign full       = (count_reg == (FIFO_PTR_WIDTH + 1)'(FIFO_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_item  = entry_reg[rd_ptr_reg];

    // Occupancy follows pushes and pops.
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Pointers and count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ----- sv/itra_divider.sv -----
// Iterative restoring divider: several quotient bits per cycle against an
// 8-bit divisor, giving one digit and the remaining value. Depends on itra_pkg.
module itra_divider (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [itra_pkg::VALUE_WIDTH-1:0] dividend,
    input  logic [itra_pkg::RADIX_WIDTH-1:0] divisor,
    output itra_pkg::div_result_t        result
);
    import itra_pkg::*;

    logic [VALUE_WIDTH-1:0]   quot_reg;
    logic [RADIX_WIDTH-1:0]   rem_reg;
    logic [RADIX_WIDTH-1:0]   divisor_reg;
    logic [DIV_CNT_WIDTH-1:0] cnt_reg;
    logic                     busy_reg;
    logic                     done_reg;
    logic [VALUE_WIDTH-1:0]   quot_next;
    logic [RADIX_WIDTH-1:0]   rem_next;
    logic [RADIX_WIDTH:0]     rem_ext;

    // A few shift-and-subtract steps on the narrow partial remainder.
    always_comb
    begin
        quot_next = quot_reg;
        rem_next  = rem_reg;
        rem_ext   = '0;
        for (int i = 0; i < DIV_STEPS; i++)
        begin
            rem_ext   = {rem_next, quot_next[VALUE_WIDTH-1]};
            quot_next = {quot_next[VALUE_WIDTH-2:0], 1'b0};
            if (rem_ext >= {1'b0, divisor_reg})
            begin
                rem_ext      = rem_ext - {1'b0, divisor_reg};
                quot_next[0] = 1'b1;
            end
            rem_next = rem_ext[RADIX_WIDTH-1:0];
        end
    end

    // Sequencing of the iterations.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_WIDTH'(DIV_CYCLES - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quot_reg    <= dividend;
            rem_reg     <= '0;
            divisor_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quot_reg <= quot_next;
            rem_reg  <= rem_next;
        end
    end

    assign result.done = done_reg;
    assign result.quot = quot_reg;
    assign result.rem  = rem_reg;

endmodule

// ----- sv/itra_back.sv -----
// Back end: runs the divider per digit, stacks digit characters and sends
// them most significant first through an output register.
// Depends on itra_pkg, itra_divider and integer_to_radix_ascii_assert.svh.
`include "integer_to_radix_ascii_assert.svh"

module itra_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  head_valid,
    input  itra_pkg::front_item_t head_item,
    output logic                  pop,
    output logic                  text_valid,
    input  logic                  text_ready,
    output itra_pkg::text_item_t  text_item
);
    import itra_pkg::*;

    back_state_t            state_reg;
    back_state_t            state_next;
    logic [VALUE_WIDTH-1:0] mag_reg;
    logic [RADIX_WIDTH-1:0] radix_reg;
    logic                   zero_reg;
    logic [DEPTH_WIDTH-1:0] depth_reg;
    logic [CHAR_WIDTH-1:0]  digit_reg [MAX_DIGITS];
    logic                   text_valid_reg;
    text_item_t             text_item_reg;

    logic                   out_free;
    logic                   out_load;
    text_item_t             out_item;
    logic                   div_start;
    logic                   digit_push;
    logic                   digit_pop;
    logic [IDX_WIDTH-1:0]   top_idx;
    div_result_t            div_res;

    itra_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (mag_reg),
        .divisor  (radix_reg),
        .result   (div_res)
    );

    // The output register can take a character when empty or draining.
    assign out_free = !text_valid_reg || text_ready;
    assign top_idx  = IDX_WIDTH'(depth_reg - 1'b1);

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (head_valid)
                begin
                    if (head_item.show_minus)
                    begin
                        state_next = S_SIGN;
                    end
                    else if (head_item.is_zero)
                    begin
                        state_next = S_ZERO;
                    end
                    else
                    begin
                        state_next = S_START;
                    end
                end
            end
            S_SIGN:
            begin
                if (out_free)
                begin
                    state_next = zero_reg ? S_ZERO : S_START;
                end
            end
            S_ZERO:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_START:
            begin
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (div_res.done)
                begin
                    state_next = (div_res.quot == '0) ? S_EMIT : S_START;
                end
            end
            S_EMIT:
            begin
                if (out_free && (depth_reg == DEPTH_WIDTH'(1)))
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output and control decode.
    always_comb
    begin
        pop                = 1'b0;
        div_start          = 1'b0;
        digit_push         = 1'b0;
        digit_pop          = 1'b0;
        out_load           = 1'b0;
        out_item.char_code = CH_ZERO;
        out_item.last_char = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                pop = head_valid;
            end
            S_SIGN:
            begin
                out_load           = out_free;
                out_item.char_code = CH_MINUS;
            end
            S_ZERO:
            begin
                out_load           = out_free;
                out_item.last_char = 1'b1;
            end
            S_START:
            begin
                div_start = 1'b1;
            end
            S_WAIT:
            begin
                digit_push = div_res.done;
            end
            S_EMIT:
            begin
                out_load           = out_free;
                digit_pop          = out_free;
                out_item.char_code = digit_reg[top_idx];
                out_item.last_char = (depth_reg == DEPTH_WIDTH'(1));
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            depth_reg      <= '0;
            text_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (digit_push)
            begin
                depth_reg <= depth_reg + 1'b1;
            end
            else if (digit_pop)
            begin
                depth_reg <= depth_reg - 1'b1;
            end
            if (out_load)
            begin
                text_valid_reg <= 1'b1;
            end
            else if (text_ready)
            begin
                text_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: working value, digit stack, output character.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            mag_reg   <= head_item.mag;
            radix_reg <= head_item.radix;
            zero_reg  <= head_item.is_zero;
        end
        else if (digit_push)
        begin
            mag_reg <= div_res.quot;
        end
        if (digit_push)
        begin
            digit_reg[depth_reg[IDX_WIDTH-1:0]] <= digit_char(div_res.rem);
        end
        if (out_load)
        begin
            text_item_reg <= out_item;
        end
    end

    assign text_valid = text_valid_reg;
    assign text_item  = text_item_reg;

    // Consistency checks on sequencing and the digit stack.
    `ITRA_ASSERT_NOW(a_done_in_wait, div_res.done, state_reg == S_WAIT)
    `ITRA_ASSERT_NOW(a_rem_below_radix, div_res.done, div_res.rem < radix_reg)
    `ITRA_ASSERT_NOW(a_depth_bound, 1'b1, depth_reg <= DEPTH_WIDTH'(MAX_DIGITS))
    `ITRA_ASSERT_NOW(a_emit_nonempty, state_reg == S_EMIT, depth_reg != '0)
    `ITRA_ASSERT_NEXT(a_last_to_idle, out_load && out_item.last_char, state_reg == S_IDLE)

endmodule

// ----- sv/integer_to_radix_ascii.sv -----
// Integer to radix ASCII converter, top level. Each digit takes one pass of the divider
// (4 quotient bits per cycle); the digits are then sent from a stack, most significant first.
// The back end finishes one item before it takes the next from the queue.
// The front end queues up to two items while the back end works.
// Asynchronous active-low reset clears all control state; no clearing pass is needed.
module integer_to_radix_ascii (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  value_valid,
    output logic                  value_ready,
    input  itra_pkg::value_item_t value_item,
    output logic                  text_valid,
    input  logic                  text_ready,
    output itra_pkg::text_item_t  text_item
);
    import itra_pkg::*;

    logic        queue_full;
    logic        queue_push;
    front_item_t queue_item;
    logic        head_valid;
    front_item_t head_item;
    logic        queue_pop;

    // Classification of incoming transfers.
    itra_front u_front (
        .value_valid (value_valid),
        .value_ready (value_ready),
        .value_item  (value_item),
        .queue_full  (queue_full),
        .queue_push  (queue_push),
        .queue_item  (queue_item)
    );

    // Decoupling queue.
    itra_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (queue_push),
        .push_item  (queue_item),
        .pop        (queue_pop),
        .full       (queue_full),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    // Digit generation and character output.
    itra_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (queue_pop),
        .text_valid (text_valid),
        .text_ready (text_ready),
        .text_item  (text_item)
    );

endmodule

// ----- tb/tb_integer_to_radix_ascii.sv -----
// Self-checking testbench for the integer to radix ASCII converter.
// Predicts each character string from the input transfer and checks the result stream.
// Depends on itra_pkg and the integer_to_radix_ascii RTL.
module tb_integer_to_radix_ascii;

    import itra_pkg::*;

    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 400;

    logic        clk;
    logic        rst_n       = 1'b0;
    logic        value_valid = 1'b0;
    logic        value_ready;
    value_item_t value_item  = '0;
    logic        text_valid;
    logic        text_ready  = 1'b0;
    text_item_t  text_item;

    // Characters still owed by the block, oldest first.
    text_item_t expected_text[$];

    // When set, neither side inserts idle cycles.
    logic no_idle = 1'b0;

    int items_sent     = 0;
    int chars_checked  = 0;
    int failures       = 0;
    int stalled_cycles = 0;

    integer_to_radix_ascii uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .value_valid (value_valid),
        .value_ready (value_ready),
        .value_item  (value_item),
        .text_valid  (text_valid),
        .text_ready  (text_ready),
        .text_item   (text_item)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void push_char(input logic [CHAR_WIDTH-1:0] code, input logic last);
        text_item_t entry;
        entry.char_code = code;
        entry.last_char = last;
        expected_text.push_back(entry);
    endfunction

    // Work out the characters that one conversion produces, most significant digit first.
    function automatic void predict_text(input value_item_t item);
        logic [VALUE_WIDTH-1:0] magnitude;
        logic [VALUE_WIDTH-1:0] remainder;
        logic [CHAR_WIDTH-1:0]  digits[$];
        magnitude = item.value_bits[VALUE_WIDTH-1:0];
        if (item.signed_mode && magnitude[VALUE_WIDTH-1])
        begin
            // Only decimal output carries a sign; other radices print the bare magnitude.
            if (item.radix == RADIX_DEC)
            begin
                push_char(CH_MINUS, 1'b0);
            end
            magnitude = VALUE_WIDTH'(-magnitude);
        end
        if (magnitude == '0 || item.radix < RADIX_MIN)
        begin
            push_char(CH_ZERO, 1'b1);
            return;
        end
        while (magnitude != '0)
        begin
            remainder = magnitude % item.radix;
            if (remainder > DIGIT_MAX)
            begin
                digits.push_front(CHAR_WIDTH'(remainder[7:0] - RADIX_DEC + CH_UPPER_A));
            end
            else
            begin
                digits.push_front(CHAR_WIDTH'(remainder[7:0] + CH_ZERO));
            end
            magnitude = magnitude / item.radix;
        end
        foreach (digits[i])
        begin
            push_char(digits[i], i == digits.size() - 1);
        end
    endfunction

    function automatic value_item_t make_item(input logic [FIELD_WIDTH-1:0] bits,
                                              input logic sgn,
                                              input logic [RADIX_WIDTH-1:0] base);
        value_item_t item;
        item.value_bits  = bits;
        item.signed_mode = sgn;
        item.radix       = base;
        return item;
    endfunction

    // Mostly ordinary radices with varied value shapes, plus degenerate and wide radices.
    function automatic value_item_t random_value_item();
        value_item_t item;
        int          shape;
        int          base_pick;
        shape     = $urandom_range(9);
        base_pick = $urandom_range(99);
        case (shape)
            0, 1, 2, 3: item.value_bits = $urandom;
            4, 5:       item.value_bits = $urandom_range(1000);
            6:          item.value_bits = $urandom >> $urandom_range(31);
            7:          item.value_bits = -$urandom_range(1, 1000);
            8:          item.value_bits = 32'h8000_0000 ^ $urandom_range(3);
            default:    item.value_bits = 32'hFFFF_FFFF ^ $urandom_range(3);
        endcase
        item.signed_mode = 1'($urandom_range(1));
        if (base_pick < 65)
        begin
            item.radix = RADIX_WIDTH'($urandom_range(2, 36));
        end
        else if (base_pick < 80)
        begin
            item.radix = ($urandom_range(1) == 1) ? RADIX_DEC : 8'd16;
        end
        else if (base_pick < 88)
        begin
            item.radix = RADIX_WIDTH'($urandom_range(1));
        end
        else
        begin
            item.radix = RADIX_WIDTH'($urandom_range(37, 255));
        end
        return item;
    endfunction

    // Offer one input transfer; called and returning at a falling edge.
    task automatic send_value(input value_item_t item);
        int gap;
        gap = 0;
        if (!no_idle)
        begin
            while ($urandom_range(99) < 35)
            begin
                gap++;
            end
        end
        if (gap > 0)
        begin
            value_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        value_valid <= 1'b1;
        value_item  <= item;
        do
        begin
            @(posedge clk);
        end
        while (!value_ready);
        predict_text(item);
        items_sent++;
        @(negedge clk);
    endtask

    // Receiver side: ready toggles at random except during the burst test.
    always @(negedge clk)
    begin
        text_ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 35);
    end

    // Compare each output transfer with the oldest predicted character.
    always @(posedge clk)
    begin
        text_item_t want;
        if (rst_n && text_valid && text_ready)
        begin
            if (expected_text.size() == 0)
            begin
                $display("%0t: unexpected character, expected none, got %02h last %b",
                         $time, text_item.char_code, text_item.last_char);
                failures++;
            end
            else
            begin
                want = expected_text.pop_front();
                chars_checked++;
                if (text_item.char_code !== want.char_code)
                begin
                    $display("%0t: char_code mismatch, expected %02h, got %02h",
                             $time, want.char_code, text_item.char_code);
                    failures++;
                end
                if (text_item.last_char !== want.last_char)
                begin
                    $display("%0t: last_char mismatch, expected %b, got %b",
                             $time, want.last_char, text_item.last_char);
                    failures++;
                end
            end
        end
    end

    // Watchdog: too many cycles without any transfer ends the run.
    always @(posedge clk)
    begin
        if ((value_valid && value_ready) || (text_valid && text_ready) || !rst_n)
        begin
            stalled_cycles <= 0;
        end
        else if (stalled_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
        else
        begin
            stalled_cycles <= stalled_cycles + 1;
        end
    end

    // Zero values and radices of zero and one, signed and unsigned.
    task automatic test_zero_and_degenerate_radix();
        send_value(make_item(32'd0, 1'b0, RADIX_DEC));
        send_value(make_item(32'd0, 1'b1, RADIX_DEC));
        send_value(make_item(32'd12345, 1'b0, 8'd0));
        send_value(make_item(32'hFFFF_FFFF, 1'b1, 8'd0));
        send_value(make_item(32'd999, 1'b0, 8'd1));
        send_value(make_item(32'h8000_0000, 1'b1, 8'd1));
    endtask

    // Longest strings, the most negative value, sign handling and wrapped digit codes.
    task automatic test_extreme_values();
        send_value(make_item(32'hFFFF_FFFF, 1'b0, RADIX_MIN));
        send_value(make_item(32'h8000_0000, 1'b1, RADIX_MIN));
        send_value(make_item(32'h8000_0000, 1'b1, RADIX_DEC));
        send_value(make_item(32'h8000_0000, 1'b1, 8'd16));
        send_value(make_item(32'hFFFF_FFFF, 1'b1, RADIX_DEC));
        send_value(make_item(32'hFFFF_FFFF, 1'b1, 8'd16));
        send_value(make_item(32'h7FFF_FFFF, 1'b1, RADIX_DEC));
        send_value(make_item(32'hFFFF_FFFF, 1'b0, RADIX_DEC));
        send_value(make_item(32'hFFFF_FFFF, 1'b0, 8'd36));
        send_value(make_item(32'hDEAD_BEEF, 1'b0, 8'd16));
        send_value(make_item(32'd35, 1'b0, 8'd36));
        send_value(make_item(32'd36, 1'b0, 8'd37));
        send_value(make_item(32'hFFFF_FFFF, 1'b0, 8'd255));
        send_value(make_item(32'd254, 1'b0, 8'd255));
        send_value(make_item(32'd1, 1'b0, RADIX_MIN));
        send_value(make_item(32'd12345678, 1'b1, 8'd8));
        send_value(make_item(32'hFFFF_FFFB, 1'b1, 8'd3));
        send_value(make_item(32'hFFFF_FFFF, 1'b0, 8'd254));
    endtask

    // Random conversions with idle cycles on both sides.
    task automatic test_random_conversions(input int count);
        repeat (count)
        begin
            send_value(random_value_item());
        end
    endtask

    // Back-to-back transfers with no idling on either side.
    task automatic test_back_to_back_burst(input int count);
        no_idle = 1'b1;
        repeat (count)
        begin
            send_value(random_value_item());
        end
        no_idle = 1'b0;
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_zero_and_degenerate_radix();
        test_extreme_values();
        test_random_conversions(356);
        test_back_to_back_burst(50);
        value_valid <= 1'b0;

        while (expected_text.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Converted %0d values in radices 0 to 255, signed and unsigned,", items_sent);
        $display("and checked %0d output characters against the prediction.", chars_checked);
        if (failures == 0 && expected_text.size() == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+sv
sv/itra_pkg.sv
sv/itra_front.sv
sv/itra_fifo.sv
sv/itra_divider.sv
sv/itra_back.sv
sv/integer_to_radix_ascii.sv
tb/tb_integer_to_radix_ascii.sv
